// ===== sv/reliable_udp_ack_tracker_core_macros.svh =====
// Assertion macros for the ack tracker.
`ifndef RELIABLE_UDP_ACK_TRACKER_CORE_MACROS_SVH
`define RELIABLE_UDP_ACK_TRACKER_CORE_MACROS_SVH
// Same-cycle implication, off during reset.
`define RUAT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, off during reset.
`define RUAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ===== sv/ruat_pkg.sv =====
// Shared types and constants of the ack tracker.
package ruat_pkg;
  localparam int DEPTH = 32;
  localparam int SEQ_W = 16;
  localparam int ENT_W = 17;
  localparam int CNT_W = 6;

  localparam logic ACT_RECV = 1'b0;
  localparam logic ACT_SEND = 1'b1;

  typedef struct packed {
    logic        action;
    logic [15:0] seq_num;
    logic [15:0] ack_num;
    logic [31:0] ack_bits_in;
    logic        ensure_flag;
  } in_t;

  typedef struct packed {
    logic [15:0] remote_seq;
    logic [15:0] local_seq;
    logic [30:0] ack_bits_out;
    logic        lost_valid;
    logic [15:0] lost_seq;
    logic        resend_req;
    logic [5:0]  stat_count;
    logic [5:0]  stat_lost;
    logic [5:0]  delivered_now;
  } out_t;

  typedef struct packed {
    logic             vld;
    logic [ENT_W-1:0] data;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic rotate;
  } chain_ctl_t;
endpackage

// ===== sv/ruat_cell.sv =====
// One window cell: an entry register loaded from its neighbor.
module ruat_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  ruat_pkg::entry_t d,
  output ruat_pkg::entry_t q
);
  ruat_pkg::entry_t q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else if (en) begin
      q_r.vld <= d.vld;
    end
    if (en) begin
      q_r.data <= d.data;
    end
  end

  assign q = q_r;
endmodule

// ===== sv/ruat_chain.sv =====
// Window as a row of cells: push at the head, or rotate tail back to head.
module ruat_chain (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ruat_pkg::chain_ctl_t      ctl,
  input  logic [ruat_pkg::ENT_W-1:0] push_data,
  output ruat_pkg::entry_t          tail
);
  ruat_pkg::entry_t q [ruat_pkg::DEPTH];
  ruat_pkg::entry_t head_d;

  always_comb begin
    if (ctl.rotate) begin
      head_d = q[ruat_pkg::DEPTH-1];
    end else begin
      head_d.vld  = 1'b1;
      head_d.data = push_data;
    end
  end

  for (genvar i = 0; i < ruat_pkg::DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      ruat_cell u_cell (.clk(clk), .rst_n(rst_n), .en(ctl.shift), .d(head_d), .q(q[i]));
    end else begin : g_body
      ruat_cell u_cell (.clk(clk), .rst_n(rst_n), .en(ctl.shift), .d(q[i-1]), .q(q[i]));
    end
  end

  assign tail = q[ruat_pkg::DEPTH-1];
endmodule

// ===== sv/reliable_udp_ack_tracker_core.sv =====
// Top level of the reliable-UDP ack tracker.
// Tracks remote/local sequences and four 32-entry windows (received
// sequences, sent packets with ensure flag, delivered sequences, delivery
// statistics), each a row of cells that shifts on a push and can rotate so
// its tail passes every entry. One event at a time: a received event runs
// 33 delivery steps while the received window rotates to rebuild the ack
// bitfield, then a finish step; a sent event rotates the delivered window
// to look up the evicted packet, then takes an update step and a finish
// step. Those window walks set the rate. The input is free again once the
// result loads. A result beat waits in an output register; the next event
// is accepted while it waits, and its finish step holds until the register
// frees.
module reliable_udp_ack_tracker_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  ruat_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output ruat_pkg::out_t  out_data
);
`include "reliable_udp_ack_tracker_core_macros.svh"

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RECV = 2'd1;
  localparam logic [1:0] ST_SEND = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;
  localparam logic [5:0] LAST_STEP = 6'd32;

  logic [1:0]  state_r, state_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [15:0] remote_r, remote_nxt;
  logic [15:0] local_r, local_nxt;
  logic [15:0] seq_r, ack_r;
  logic [31:0] bits_r;
  logic [16:0] entry_r;
  logic [30:0] acc_r, acc_nxt;
  logic [30:0] ack_bits_r, ack_bits_nxt;
  logic        found_r, found_nxt;
  logic        lost_r, lost_nxt;
  logic [15:0] lost_seq_r, lost_seq_nxt;
  logic        resend_r, resend_nxt;
  logic [5:0]  deliv_now_r, deliv_now_nxt;
  logic [5:0]  stat_fill_r, stat_fill_nxt;
  logic [5:0]  stat_ones_r, stat_ones_nxt;
  logic        out_valid_r, out_valid_nxt;
  ruat_pkg::out_t out_r, out_nxt;

  ruat_pkg::chain_ctl_t recv_ctl, deliv_ctl, sent_ctl, stat_ctl;
  logic [16:0] recv_push, deliv_push, sent_push, stat_push;
  ruat_pkg::entry_t recv_tail, deliv_tail, sent_tail, stat_tail;

  logic        accept;
  logic [15:0] sd, lag;
  logic        newer, dpush, stat_in, stat_en, lost_now;
  logic [15:0] dseq;

  ruat_chain u_recv  (.clk(clk), .rst_n(rst_n), .ctl(recv_ctl),  .push_data(recv_push),
                      .tail(recv_tail));
  ruat_chain u_deliv (.clk(clk), .rst_n(rst_n), .ctl(deliv_ctl), .push_data(deliv_push),
                      .tail(deliv_tail));
  ruat_chain u_sent  (.clk(clk), .rst_n(rst_n), .ctl(sent_ctl),  .push_data(sent_push),
                      .tail(sent_tail));
  ruat_chain u_stat  (.clk(clk), .rst_n(rst_n), .ctl(stat_ctl),  .push_data(stat_push),
                      .tail(stat_tail));

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // half-range wrap compare: seq more recent than remote
  assign sd    = in_data.seq_num - remote_r;
  assign newer = (sd != 16'd0) &&
                 ((sd < 16'h8000) || ((sd == 16'h8000) && (in_data.seq_num > remote_r)));

  // distance of the rotating received entry behind remote
  assign lag = remote_r - recv_tail.data[15:0];

  // delivery step: bitfield bits first, then ack itself
  assign lost_now = sent_tail.vld && !found_r;
  always_comb begin
    if (cnt_r < LAST_STEP) begin
      dpush = bits_r[cnt_r[4:0]];
      dseq  = ack_r - {10'd0, cnt_r} - 16'd1;
    end else begin
      dpush = (seq_r != 16'd0) || (ack_r != 16'd0);
      dseq  = ack_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    remote_nxt    = remote_r;
    local_nxt     = local_r;
    acc_nxt       = acc_r;
    ack_bits_nxt  = ack_bits_r;
    found_nxt     = found_r;
    lost_nxt      = lost_r;
    lost_seq_nxt  = lost_seq_r;
    resend_nxt    = resend_r;
    deliv_now_nxt = deliv_now_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    recv_ctl      = '0;
    deliv_ctl     = '0;
    sent_ctl      = '0;
    stat_ctl      = '0;
    recv_push     = {1'b0, in_data.seq_num};
    deliv_push    = {1'b0, dseq};
    sent_push     = entry_r;
    stat_in       = 1'b0;
    stat_en       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cnt_nxt       = 6'd0;
          acc_nxt       = '0;
          found_nxt     = 1'b0;
          lost_nxt      = 1'b0;
          lost_seq_nxt  = 16'd0;
          resend_nxt    = 1'b0;
          deliv_now_nxt = 6'd0;
          if (in_data.action == ruat_pkg::ACT_RECV) begin
            if (newer) begin
              remote_nxt = in_data.seq_num;
            end
            recv_ctl.shift = 1'b1;
            state_nxt      = ST_RECV;
          end else begin
            local_nxt = local_r + 16'd1;
            state_nxt = ST_SEND;
          end
        end
      end
      ST_RECV: begin
        if (cnt_r < LAST_STEP) begin
          recv_ctl.shift  = 1'b1;
          recv_ctl.rotate = 1'b1;
          if (recv_tail.vld && (lag != 16'd0) && (lag < 16'd32)) begin
            acc_nxt[5'(lag - 16'd1)] = 1'b1;
          end
          cnt_nxt = cnt_r + 6'd1;
        end else begin
          ack_bits_nxt = acc_r;
          state_nxt    = ST_FIN;
        end
        if (dpush) begin
          deliv_ctl.shift = 1'b1;
          stat_in         = 1'b1;
          stat_en         = 1'b1;
          deliv_now_nxt   = deliv_now_r + 6'd1;
        end
      end
      ST_SEND: begin
        if (cnt_r < LAST_STEP) begin
          deliv_ctl.shift  = 1'b1;
          deliv_ctl.rotate = 1'b1;
          if (deliv_tail.vld && (deliv_tail.data[15:0] == sent_tail.data[15:0])) begin
            found_nxt = 1'b1;
          end
          cnt_nxt = cnt_r + 6'd1;
        end else begin
          if (lost_now) begin
            lost_nxt     = 1'b1;
            lost_seq_nxt = sent_tail.data[15:0];
            resend_nxt   = sent_tail.data[16];
            stat_en      = 1'b1;
          end
          sent_ctl.shift = 1'b1;
          state_nxt      = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.remote_seq    = remote_r;
          out_nxt.local_seq     = local_r;
          out_nxt.ack_bits_out  = ack_bits_r;
          out_nxt.lost_valid    = lost_r;
          out_nxt.lost_seq      = lost_seq_r;
          out_nxt.resend_req    = resend_r;
          out_nxt.stat_count    = stat_fill_r;
          out_nxt.stat_lost     = stat_fill_r - stat_ones_r;
          out_nxt.delivered_now = deliv_now_r;
          out_valid_nxt         = 1'b1;
          state_nxt             = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    stat_ctl.shift = stat_en;
    stat_push      = {16'd0, stat_in};
  end

  // stat counters track the window: a full window drops its tail bit
  always_comb begin
    stat_fill_nxt = stat_fill_r;
    stat_ones_nxt = stat_ones_r;
    if (stat_en) begin
      if (stat_tail.vld) begin
        stat_ones_nxt = stat_ones_r - {5'd0, stat_tail.data[0]} + {5'd0, stat_in};
      end else begin
        stat_fill_nxt = stat_fill_r + 6'd1;
        stat_ones_nxt = stat_ones_r + {5'd0, stat_in};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= 6'd0;
      remote_r    <= 16'd0;
      local_r     <= 16'd0;
      ack_bits_r  <= '0;
      stat_fill_r <= 6'd0;
      stat_ones_r <= 6'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      remote_r    <= remote_nxt;
      local_r     <= local_nxt;
      ack_bits_r  <= ack_bits_nxt;
      stat_fill_r <= stat_fill_nxt;
      stat_ones_r <= stat_ones_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      seq_r   <= in_data.seq_num;
      ack_r   <= in_data.ack_num;
      bits_r  <= in_data.ack_bits_in;
      entry_r <= {in_data.ensure_flag, local_r};
    end
    acc_r       <= acc_nxt;
    found_r     <= found_nxt;
    lost_r      <= lost_nxt;
    lost_seq_r  <= lost_seq_nxt;
    resend_r    <= resend_nxt;
    deliv_now_r <= deliv_now_nxt;
    out_r       <= out_nxt;
  end

  `RUAT_ASSERT_NOW(a_stat_le, 1'b1, stat_ones_r <= stat_fill_r, "stat ones above fill")
  `RUAT_ASSERT_NOW(a_cnt_rng, 1'b1, cnt_r <= LAST_STEP, "step counter out of range")
  `RUAT_ASSERT_NEXT(a_busy, accept, in_stall, "accepted beat did not start work")
endmodule

// ===== tb/sv/tb_reliable_udp_ack_tracker_core.sv =====
// Testbench of the reliable-UDP ack tracker: directed table plus random events, checked by a predictor.
`timescale 1ns / 1ps

module tb_reliable_udp_ack_tracker_core;
  localparam int WIN = 32;
  localparam int STALL_PCT = 31;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM = 1300;
  localparam int EXP_DEPTH = 16;
  localparam int ROW_MAX = 32;
  // window ids of the model
  localparam int W_RECV = 0;
  localparam int W_SENT = 1;
  localparam int W_DELIV = 2;
  localparam int W_STAT = 3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  ruat_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ruat_pkg::out_t out_data;

  always #1 clk = ~clk;

  reliable_udp_ack_tracker_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // ---------------------------------------------------------------------
  // Tracker model state: sequences plus four FIFO windows, oldest at [0].
  // Sent entries are {ensure, seq}; stat entries 1 delivered, 0 lost.
  // ---------------------------------------------------------------------
  logic [15:0] trk_remote;
  logic [15:0] trk_local;
  logic [16:0] win [4][WIN];
  int          win_n [4];
  int          deliv_now;

  ruat_pkg::out_t exp_buf [EXP_DEPTH];
  int          exp_wr = 0;
  int          exp_rd = 0;
  bit          failed = 1'b0;
  bit          in_hold = 1'b0;   // idling off for a stretch
  bit          out_hold = 1'b0;

  // Wrap comparison: a newer than b within half the sequence space.
  function automatic bit seq_newer(logic [15:0] a, logic [15:0] b);
    if (a > b) return (a - b) <= 17'd32768;
    if (a < b) return (b - a) > 17'd32768;
    return 1'b0;
  endfunction

  function automatic bit win_has(int w, logic [16:0] v);
    for (int i = 0; i < win_n[w]; i++) if (win[w][i] == v) return 1'b1;
    return 1'b0;
  endfunction

  // push into a window, dropping the oldest entry when full
  task automatic win_add(int w, logic [16:0] v);
    if (win_n[w] >= WIN) begin
      for (int i = 0; i < WIN - 1; i++) win[w][i] = win[w][i+1];
      win_n[w] = WIN - 1;
    end
    win[w][win_n[w]] = v;
    win_n[w] = win_n[w] + 1;
  endtask

  task automatic note_delivery(logic [15:0] s);
    win_add(W_DELIV, {1'b0, s});
    win_add(W_STAT, 17'd1);
    deliv_now++;
  endtask

  task automatic tracker_reset();
    trk_remote = '0;
    trk_local  = '0;
    for (int w = 0; w < 4; w++) win_n[w] = 0;
  endtask

  // Apply one event to the model and return the result it should produce.
  task automatic track_event(input ruat_pkg::in_t ev, output ruat_pkg::out_t res);
    logic [16:0] old;
    int          losses;
    res = '0;
    deliv_now = 0;
    if (ev.action == ruat_pkg::ACT_RECV) begin
      if (seq_newer(ev.seq_num, trk_remote)) trk_remote = ev.seq_num;
      for (int k = 0; k < 32; k++)
        if (ev.ack_bits_in[k]) note_delivery(ev.ack_num - 16'(k + 1));
      // first-packet rule: seq and ack both zero means no ack yet
      if (ev.seq_num != 16'd0 || ev.ack_num != 16'd0) note_delivery(ev.ack_num);
      win_add(W_RECV, {1'b0, ev.seq_num});
    end else begin
      if (win_n[W_SENT] >= WIN) begin
        old = win[W_SENT][0];
        if (!win_has(W_DELIV, {1'b0, old[15:0]})) begin
          res.lost_valid = 1'b1;
          res.lost_seq   = old[15:0];
          res.resend_req = old[16];
          win_add(W_STAT, 17'd0);
        end
      end
      win_add(W_SENT, {ev.ensure_flag, trk_local});
      trk_local = trk_local + 16'd1;
    end
    losses = 0;
    for (int i = 0; i < win_n[W_STAT]; i++) if (win[W_STAT][i][0] == 1'b0) losses++;
    res.remote_seq = trk_remote;
    res.local_seq  = trk_local;
    for (int k = 1; k < WIN; k++)
      res.ack_bits_out[k-1] = win_has(W_RECV, {1'b0, trk_remote - 16'(k)});
    res.stat_count    = 6'(win_n[W_STAT]);
    res.stat_lost     = 6'(losses);
    res.delivered_now = 6'(deliv_now);
  endtask

  // ---------------------------------------------------------------------
  // Directed table. A row with has_exp set also carries a typed-in result
  // that must agree with the predictor.
  // ---------------------------------------------------------------------
  typedef struct {
    ruat_pkg::in_t  ev;
    bit             has_exp;
    ruat_pkg::out_t exp_res;
  } row_t;

  row_t rows [ROW_MAX];
  int   n_rows = 0;
  int   watchdog = 0;

  task automatic add_row(logic act, logic [15:0] s, logic [15:0] a, logic [31:0] b,
                         logic f);
    rows[n_rows].ev = '{action: act, seq_num: s, ack_num: a, ack_bits_in: b,
                        ensure_flag: f};
    rows[n_rows].has_exp = 1'b0;
    rows[n_rows].exp_res = '0;
    n_rows++;
  endtask

  task automatic expect_last(ruat_pkg::out_t e);
    rows[n_rows-1].has_exp = 1'b1;
    rows[n_rows-1].exp_res = e;
  endtask

  task automatic build_table();
    ruat_pkg::out_t e;
    // first packet after reset: nothing counted, nothing received yet
    add_row(ruat_pkg::ACT_RECV, 16'h0000, 16'h0000, 32'h0, 1'b1);
    e = '0;
    expect_last(e);
    // zero seq and ack with all ack bits: 32 deliveries, ack itself skipped
    add_row(ruat_pkg::ACT_RECV, 16'h0000, 16'h0000, 32'hFFFF_FFFF, 1'b0);
    e = '0;
    e.stat_count = 6'd32;
    e.delivered_now = 6'd32;
    expect_last(e);
    // wrap comparison edges
    add_row(ruat_pkg::ACT_RECV, 16'h8000, 16'hFFFF, 32'h8000_0001, 1'b1);
    add_row(ruat_pkg::ACT_RECV, 16'h0001, 16'h0001, 32'h0, 1'b0);
    add_row(ruat_pkg::ACT_RECV, 16'hFFFF, 16'h0000, 32'h5555_5555, 1'b0);
    add_row(ruat_pkg::ACT_RECV, 16'h7FFF, 16'h1234, 32'hAAAA_AAAA, 1'b1);
    add_row(ruat_pkg::ACT_RECV, 16'h7FFE, 16'hFFFE, 32'h0000_0000, 1'b0);
    // sent events, ignored fields at extremes
    add_row(ruat_pkg::ACT_SEND, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    add_row(ruat_pkg::ACT_SEND, 16'h0000, 16'h0000, 32'h0, 1'b0);
    for (int i = 0; i < 14; i++) add_row(ruat_pkg::ACT_SEND, 16'($urandom), 16'($urandom),
                                         $urandom, i[0]);
  endtask

  // ---------------------------------------------------------------------
  // Result side: random stall, check each beat against the oldest entry.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (exp_wr == exp_rd) begin
        $display("%0t: result beat with none expected, actual %p", $time, out_data);
        failed = 1'b1;
      end else begin
        if (out_data !== exp_buf[exp_rd % EXP_DEPTH]) begin
          $display("%0t: mismatch expected %p actual %p", $time,
                   exp_buf[exp_rd % EXP_DEPTH], out_data);
          failed = 1'b1;
        end
        exp_rd = exp_rd + 1;
      end
    end
  end

  always @(negedge clk)
    out_stall <= !out_hold && ($urandom_range(99) < STALL_PCT);

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) watchdog <= 0;
    else watchdog <= watchdog + 1;
    if (watchdog >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Drive one event at a falling edge: optional idle gap, then hold valid
  // until accepted. Returns at the accepting edge.
  task automatic send_event(input ruat_pkg::in_t ev, output ruat_pkg::out_t res);
    @(negedge clk);
    while (!in_hold && $urandom_range(99) < STALL_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    track_event(ev, res);
    exp_buf[exp_wr % EXP_DEPTH] = res;
    exp_wr = exp_wr + 1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Random event: mostly plausible traffic around the live sequences.
  function automatic ruat_pkg::in_t random_event();
    ruat_pkg::in_t ev;
    ev.action      = 1'($urandom_range(1));
    ev.ensure_flag = 1'($urandom_range(1));
    case ($urandom_range(9))
      0: begin
        ev.seq_num     = 16'($urandom);
        ev.ack_num     = 16'($urandom);
        ev.ack_bits_in = $urandom;
      end
      default: begin
        ev.seq_num     = trk_remote + 16'($urandom_range(4)) - 16'd1;
        ev.ack_num     = trk_local - 16'($urandom_range(3));
        ev.ack_bits_in = ($urandom_range(3) == 0) ? 32'h0 : ($urandom & $urandom);
      end
    endcase
    return ev;
  endfunction

  initial begin
    ruat_pkg::out_t res;
    tracker_reset();
    build_table();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part: a typed-in expectation must match the predictor too
    for (int i = 0; i < n_rows; i++) begin
      send_event(rows[i].ev, res);
      if (rows[i].has_exp && (res !== rows[i].exp_res)) begin
        $display("%0t: table row %0d expected %p actual %p", $time, i,
                 rows[i].exp_res, res);
        failed = 1'b1;
      end
    end

    // random part; a quiet stretch in the middle and a full drain pause
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 300) begin
        in_hold = 1'b1;
        out_hold = 1'b1;
      end
      if (n == 450) begin
        in_hold = 1'b0;
        out_hold = 1'b0;
      end
      if (n == 700) begin
        drop_valid();
        wait (exp_wr == exp_rd);
      end
      send_event(random_event(), res);
    end

    drop_valid();
    wait (exp_wr == exp_rd);
    repeat (80) @(posedge clk);
    if (!failed && exp_wr == exp_rd) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
